// ===== design/bilinear_upscaler_assert.svh =====
// Assertion macros used by the bilinear upscaler controller.
`ifndef BILINEAR_UPSCALER_ASSERT_SVH
`define BILINEAR_UPSCALER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define BU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bilinear_upscaler: implication check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define BU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bilinear_upscaler: next-cycle check failed");
`else
`define BU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/bu_pkg.sv =====
// Shared types, register indexes and the weight table of the bilinear upscaler.
package bu_pkg;

    // Field widths.
    localparam int PIX_W      = 16;
    localparam int IDX_W      = 13;
    localparam int WGT_W      = 13;
    localparam int SCALE_W    = 4;
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_DATA_W = 48;
    localparam int HEIGHT_MAX = 2047;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y      = 2'd3;

    // Q1.12 weights floor(k * 4096 / d), row d = scale - 1, column k.
    localparam logic [WGT_W-1:0] WTAB [8][8] = '{
        '{13'd0, 13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0},
        '{13'd0, 13'd4096, 13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0},
        '{13'd0, 13'd2048, 13'd4096, 13'd0,    13'd0,    13'd0,    13'd0,    13'd0},
        '{13'd0, 13'd1365, 13'd2730, 13'd4096, 13'd0,    13'd0,    13'd0,    13'd0},
        '{13'd0, 13'd1024, 13'd2048, 13'd3072, 13'd4096, 13'd0,    13'd0,    13'd0},
        '{13'd0, 13'd819,  13'd1638, 13'd2457, 13'd3276, 13'd4096, 13'd0,    13'd0},
        '{13'd0, 13'd682,  13'd1365, 13'd2048, 13'd2730, 13'd3413, 13'd4096, 13'd0},
        '{13'd0, 13'd585,  13'd1170, 13'd1755, 13'd2340, 13'd2925, 13'd3510, 13'd4096}
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             capture;
        logic             load;
        logic             issue;
        logic             last;
        logic [WGT_W-1:0] wx;
        logic [WGT_W-1:0] wy;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic advance;
    } t_dp_stat;

endpackage

// ===== design/bu_datapath.sv =====
// Datapath: line store, neighbour registers, interpolation pipeline and output register.
module bu_datapath
    import bu_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  logic [PIX_W-1:0]             i_pixel,
    output t_dp_stat                     o_stat,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // Fields from bit 0 up: pixel_out[15:0], out_row[28:16], out_col[41:29], zero pad.
    output logic [OUT_DATA_W-1:0]        o_m_axis_tdata,
    output logic                         o_m_axis_tlast
);

    logic [PIX_W-1:0] mem [MAX_WIDTH];

    logic [PIX_W-1:0]        r_rd;
    logic [PIX_W-1:0]        r_pix;
    logic [PIX_W-1:0]        r_ul;
    logic [PIX_W-1:0]        r_left;
    logic signed [15:0]      r_a;
    logic signed [16:0]      r_dab;
    logic signed [15:0]      r_c;
    logic signed [16:0]      r_ddc;

    logic                    r_v1, r_v2, r_v3, r_ov;
    logic signed [29:0]      r_top1, r_bot1, r_top2, r_diff2;
    logic signed [43:0]      r_s3;
    logic [WGT_W-1:0]        r_wy1, r_wy2;
    logic [IDX_W-1:0]        r_row1, r_row2, r_row3, r_row4;
    logic [IDX_W-1:0]        r_col1, r_col2, r_col3, r_col4;
    logic                    r_last1, r_last2, r_last3, r_last4;
    logic [PIX_W-1:0]        r_pout;
    logic                    advance;

    // The whole pipeline moves when the output register is empty or being taken.
    assign advance        = !r_ov || i_m_axis_tready;
    assign o_stat.advance = advance;

    // Line store: the old entry is read while the new pixel is written.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            mem[i_addr] <= i_pixel;
            r_rd        <= mem[i_addr];
            r_pix       <= i_pixel;
        end
    end

    // Neighbour registers advance once per accepted pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ul   <= '0;
            r_left <= '0;
        end else if (i_cmd.load) begin
            r_ul   <= r_rd;
            r_left <= r_pix;
        end
    end

    // Cell corners and horizontal differences for the burst.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= $signed(r_ul);
            r_dab <= 17'($signed(r_rd)) - 17'($signed(r_ul));
            r_c   <= $signed(r_left);
            r_ddc <= 17'($signed(r_pix)) - 17'($signed(r_left));
        end
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    // Stage one: horizontal blend of the top and bottom edges, scaled by 4096.
    // Stage two: vertical difference.
    // Stage three: vertical blend and rounding bias.
    // Stage four: output register, floor shift by 24.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_top1  <= (30'(r_a) <<< 12) + 30'(r_dab) * $signed({1'b0, i_cmd.wx});
            r_bot1  <= (30'(r_c) <<< 12) + 30'(r_ddc) * $signed({1'b0, i_cmd.wx});
            r_wy1   <= i_cmd.wy;
            r_row1  <= i_cmd.row;
            r_col1  <= i_cmd.col;
            r_last1 <= i_cmd.last;

            r_top2  <= r_top1;
            r_diff2 <= r_bot1 - r_top1;
            r_wy2   <= r_wy1;
            r_row2  <= r_row1;
            r_col2  <= r_col1;
            r_last2 <= r_last1;

            r_s3    <= (44'(r_top2) <<< 12) + 44'(r_diff2) * $signed({1'b0, r_wy2})
                       + 44'sd8388608;
            r_row3  <= r_row2;
            r_col3  <= r_col2;
            r_last3 <= r_last2;

            r_pout  <= r_s3[39:24];
            r_row4  <= r_row3;
            r_col4  <= r_col3;
            r_last4 <= r_last3;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {6'b0, r_col4, r_row4, r_pout};
    assign o_m_axis_tlast  = r_last4;

endmodule

// ===== design/bu_ctrl.sv =====
// Controller: configuration registers, raster counters and the burst state machine.
`include "bilinear_upscaler_assert.svh"
module bu_ctrl
    import bu_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_SCALE = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output t_dp_cmd                      o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] o_addr,
    input  t_dp_stat                     i_stat
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CNT_W = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int PW    = (CW + SCALE_W > IDX_W) ? CW + SCALE_W : IDX_W;
    localparam int KW    = $clog2(MAX_SCALE);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         r_state;
    logic [DIM_W-1:0]   r_cfg_width, r_cfg_height;
    logic [SCALE_W-1:0] r_cfg_sx, r_cfg_sy;
    logic [CW-1:0]      r_col, r_cell_c;
    logic [ROW_W-1:0]   r_row, r_cell_r;
    logic [KW-1:0]      r_kx, r_ky;
    logic [IDX_W-1:0]   r_row_base, r_col_base;

    logic [CNT_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [SCALE_W-1:0] sx_eff, sy_eff;
    logic               accept, col_end, row_end, kx_end, ky_end, issue;
    logic               emitting;
    logic [14:0]        row_prod;
    logic [PW-1:0]      col_prod;

    // Effective register values after clamping.
    always_comb begin
        if (r_cfg_width < DIM_W'(2)) begin
            w_eff = CNT_W'(2);
        end else if (CNT_W'(r_cfg_width) > CNT_W'(MAX_WIDTH)) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(r_cfg_width);
        end
        h_eff = (r_cfg_height < DIM_W'(2)) ? DIM_W'(2) : r_cfg_height;
        if (r_cfg_sx < SCALE_W'(2)) begin
            sx_eff = SCALE_W'(2);
        end else if (r_cfg_sx > SCALE_W'(MAX_SCALE)) begin
            sx_eff = SCALE_W'(MAX_SCALE);
        end else begin
            sx_eff = r_cfg_sx;
        end
        if (r_cfg_sy < SCALE_W'(2)) begin
            sy_eff = SCALE_W'(2);
        end else if (r_cfg_sy > SCALE_W'(MAX_SCALE)) begin
            sy_eff = SCALE_W'(MAX_SCALE);
        end else begin
            sy_eff = r_cfg_sy;
        end
    end

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= DIM_W'(2);
            r_cfg_height <= DIM_W'(2);
            r_cfg_sx     <= SCALE_W'(2);
            r_cfg_sy     <= SCALE_W'(2);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                REG_SCALE_X:      r_cfg_sx     <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_Y:      r_cfg_sy     <= i_cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    // Handshake and end-of-line, end-of-frame and end-of-burst decisions.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && (r_state == S_IDLE);
    assign col_end         = (CNT_W'(r_col) + CNT_W'(1)) >= w_eff;
    assign row_end         = (12'(r_row) + 12'd1) >= 12'(h_eff);
    assign kx_end          = (SCALE_W'(r_kx) == (sx_eff - SCALE_W'(1)));
    assign ky_end          = (SCALE_W'(r_ky) == (sy_eff - SCALE_W'(1)));
    assign emitting        = (r_state == S_EMIT);
    assign issue           = emitting && i_stat.advance;

    // Output coordinates of the cell's top-left result.
    assign row_prod = 15'(r_cell_r - ROW_W'(1)) * 15'(sy_eff);
    assign col_prod = PW'(r_cell_c - CW'(1)) * PW'(sx_eff);

    // Burst state machine with raster and burst counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_kx    <= '0;
            r_ky    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CALC;
                        if (col_end) begin
                            r_col <= '0;
                            r_row <= row_end ? '0 : r_row + ROW_W'(1);
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                    end
                end
                S_CALC: begin
                    r_kx    <= '0;
                    r_ky    <= '0;
                    r_state <= (r_cell_r != '0 && r_cell_c != '0) ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (i_stat.advance) begin
                        if (kx_end) begin
                            r_kx <= '0;
                            if (ky_end) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_ky <= r_ky + KW'(1);
                            end
                        end else begin
                            r_kx <= r_kx + KW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Position of the accepted pixel and the cell's output origin.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell_c <= r_col;
            r_cell_r <= r_row;
        end
        if (r_state == S_CALC) begin
            r_row_base <= row_prod[IDX_W-1:0];
            r_col_base <= col_prod[IDX_W-1:0];
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.capture = accept;
        o_cmd.load    = (r_state == S_CALC);
        o_cmd.issue   = issue;
        o_cmd.last    = kx_end && ky_end;
        o_cmd.wx      = WTAB[3'(sx_eff - SCALE_W'(1))][3'(r_kx)];
        o_cmd.wy      = WTAB[3'(sy_eff - SCALE_W'(1))][3'(r_ky)];
        o_cmd.row     = r_row_base + IDX_W'(r_ky);
        o_cmd.col     = r_col_base + IDX_W'(r_kx);
    end

    assign o_addr = r_col;

    `BU_ASSERT_NEXT(a_accept_then_calc, i_clk, i_rst_n, accept, r_state == S_CALC)
    `BU_ASSERT_NEXT(a_last_ends_burst, i_clk, i_rst_n, issue && o_cmd.last, r_state == S_IDLE)
    `BU_ASSERT_NEXT(a_stall_holds_pos, i_clk, i_rst_n, emitting && !issue, $stable({r_ky, r_kx}))

endmodule

// ===== design/bilinear_upscaler.sv =====
// Top level of the bilinear upscaler: controller and datapath.
//
// Input pixels (signed Q8.8) arrive in raster order on the s_axis channel, one
// transaction per pixel. Once a pixel completes a 2x2 cell (input row and
// column at least 1), the block sends scale_y * scale_x interpolated pixels on
// the m_axis channel, rows outer and columns inner, with tlast on the final one.
// Border pixels of the first row and column produce nothing.
// The cfg channel writes image_width, image_height, scale_x and scale_y by
// index; it is always ready and should be used only while the block is idle.
// Each pixel passes through the idle and calc states on the input side; a cell
// pixel then holds the input while its scale_x * scale_y results are issued, and
// a second pixel is accepted while the last results still drain. The first
// result of a burst leaves through a four-stage multiply pipeline. When the
// receiver stalls, the whole pipeline and the burst counters hold. Reset clears
// the counters and neighbour registers and sets the four registers to 2; the
// line store needs no clearing, as no entry feeds a result before it has been
// written.
module bilinear_upscaler
    import bu_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_SCALE = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // Fields from bit 0 up: pixel_in[15:0].
    input  logic [PIX_W-1:0]      i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // Fields from bit 0 up: pixel_out[15:0], out_row[28:16], out_col[41:29], zero pad.
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd                      cmd;
    t_dp_stat                     stat;
    logic [$clog2(MAX_WIDTH)-1:0] addr;

    // Sequencing of pixels and bursts.
    bu_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cmd           (cmd),
        .o_addr          (addr),
        .i_stat          (stat)
    );

    // Storage and arithmetic.
    bu_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_addr          (addr),
        .i_pixel         (i_s_axis_tdata),
        .o_stat          (stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ===== sim/bilinear_upscaler_checker.sv =====
// Checker for the bilinear upscaler: predicts every burst and compares it with the output stream.
module bilinear_upscaler_checker
    import bu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [PIX_W-1:0]      i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tlast,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_mismatches
);

    localparam int LINE_DEPTH  = 1024;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int SCALE_LIMIT = 8;
    localparam int UNITY       = 4096;

    // One interpolated pixel as it should leave the block.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_upscaled;

    t_upscaled               upscaled_q[$];
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic [SCALE_W-1:0]      scale_x_reg;
    logic [SCALE_W-1:0]      scale_y_reg;
    logic signed [PIX_W-1:0] prev_row [LINE_DEPTH];
    logic signed [PIX_W-1:0] upper_left;
    logic signed [PIX_W-1:0] left_px;
    int unsigned             col_pos;
    int unsigned             row_pos;
    int                      mismatches = 0;

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Q1.12 weight of step k when the cell is split into s samples.
    function automatic longint step_weight(int unsigned k, int unsigned s);
        return longint'((k * UNITY) / (s - 1));
    endfunction

    // Weighted sum of the four corners, rounded and shifted back to Q8.8.
    function automatic logic [PIX_W-1:0] mix_corners(
        logic signed [PIX_W-1:0] c00, logic signed [PIX_W-1:0] c01,
        logic signed [PIX_W-1:0] c10, logic signed [PIX_W-1:0] c11,
        longint wx, longint wy);
        longint acc;
        longint res;
        acc = (UNITY - wx) * (UNITY - wy) * longint'(c00)
            + wx * (UNITY - wy) * longint'(c01)
            + (UNITY - wx) * wy * longint'(c10)
            + wx * wy * longint'(c11)
            + (longint'(1) <<< 23);
        res = acc >>> 24;
        return res[PIX_W-1:0];
    endfunction

    // Works out the burst caused by one input pixel and advances the frame position.
    task automatic predict_pixel(input logic signed [PIX_W-1:0] px);
        int unsigned             w;
        int unsigned             h;
        int unsigned             sx;
        int unsigned             sy;
        int unsigned             c;
        int unsigned             r;
        int unsigned             idx;
        logic signed [PIX_W-1:0] up;
        longint                  wx;
        longint                  wy;
        t_upscaled               item;
        w  = clamp_range(32'(width_reg), 2, LINE_DEPTH);
        h  = clamp_range(32'(height_reg), 2, HEIGHT_MAX);
        sx = clamp_range(32'(scale_x_reg), 2, SCALE_LIMIT);
        sy = clamp_range(32'(scale_y_reg), 2, SCALE_LIMIT);
        c  = col_pos;
        r  = row_pos;
        up = prev_row[c[LINE_AW-1:0]];
        // A complete cell exists only from the second row and column on.
        if (r >= 1 && c >= 1) begin
            for (int unsigned ky = 0; ky < sy; ky++) begin
                wy = step_weight(ky, sy);
                for (int unsigned kx = 0; kx < sx; kx++) begin
                    wx = step_weight(kx, sx);
                    item.pixel = mix_corners(upper_left, up, left_px, px, wx, wy);
                    idx = (r - 1) * sy + ky;
                    item.row = idx[IDX_W-1:0];
                    idx = (c - 1) * sx + kx;
                    item.col = idx[IDX_W-1:0];
                    item.last = (ky == sy - 1) && (kx == sx - 1);
                    upscaled_q.push_back(item);
                end
            end
        end
        upper_left  = up;
        left_px     = px;
        prev_row[c[LINE_AW-1:0]] = px;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    function automatic void check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            mismatches++;
        end
    endfunction

    // Compares one output transaction with the oldest expected pixel.
    task automatic check_result();
        t_upscaled want;
        if (upscaled_q.size() == 0) begin
            $error("unexpected result: pixel_out %0d, out_row %0d, out_col %0d",
                   $signed(i_m_tdata[15:0]), i_m_tdata[28:16], i_m_tdata[41:29]);
            mismatches++;
        end else begin
            want = upscaled_q.pop_front();
            check_field("pixel_out", int'($signed(want.pixel)), int'($signed(i_m_tdata[15:0])));
            check_field("out_row", int'(want.row), int'(i_m_tdata[28:16]));
            check_field("out_col", int'(want.col), int'(i_m_tdata[41:29]));
            check_field("burst_last", int'(want.last), int'(i_m_tlast));
        end
    endtask

    // Watches the three channels at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg   = DIM_W'(2);
            height_reg  = DIM_W'(2);
            scale_x_reg = SCALE_W'(2);
            scale_y_reg = SCALE_W'(2);
            upper_left  = '0;
            left_px     = '0;
            col_pos     = 0;
            row_pos     = 0;
            prev_row    = '{default: '0};
            upscaled_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  width_reg   = i_cfg_data;
                    REG_IMAGE_HEIGHT: height_reg  = i_cfg_data;
                    REG_SCALE_X:      scale_x_reg = i_cfg_data[SCALE_W-1:0];
                    REG_SCALE_Y:      scale_y_reg = i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_pixel(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
        end
        o_pending    <= upscaled_q.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== sim/bilinear_upscaler_tb.sv =====
// Testbench top of the bilinear upscaler: clock, reset, stimulus and verdict.
module bilinear_upscaler_tb;
    import bu_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 320;
    localparam int SETTLE_CYCLES = 16;
    localparam int LINE_WIDTH    = 1024;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    pending;
    int                    mismatches;
    int                    snd_idle_pct = 28;
    int                    rcv_idle_pct = 61;
    int                    cycle_count  = 0;

    bilinear_upscaler DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    bilinear_upscaler_checker burst_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // Clock with a period of 20.
    initial begin
        forever #10 clk = ~clk;
    end

    // The receiver stalls at random in the share of cycles currently set.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Watchdog: a run that hangs ends as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bilinear_upscaler: mismatch");
            $finish;
        end
    end

    function automatic int unsigned frame_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
        if (v < 2) begin
            return 2;
        end
        return (v > hi) ? hi : v;
    endfunction

    // Mostly uniform samples, with the extremes and the sign boundary now and then.
    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return r[PIX_W-1:0];
        endcase
    endfunction

    // Scale data in range mostly, sometimes out of range or with junk above bit 3.
    function automatic logic [CFG_DATA_W-1:0] rand_scale();
        logic [CFG_DATA_W-1:0] v;
        logic [31:0]           junk;
        junk = $urandom;
        v = CFG_DATA_W'($urandom_range(2, 8));
        if ($urandom_range(0, 9) == 0) begin
            v = CFG_DATA_W'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 7) == 0) begin
            v[CFG_DATA_W-1:SCALE_W] = junk[CFG_DATA_W-SCALE_W-1:0];
        end
        return v;
    endfunction

    // One pixel transaction, preceded by random idle cycles.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_cfg(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every expected pixel has come out, then lets the pipeline settle.
    task automatic drain();
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Programs a setting and sends one whole frame of random pixels.
    task automatic run_random_frame(input logic [CFG_DATA_W-1:0] w,
                                    input logic [CFG_DATA_W-1:0] h,
                                    input logic [CFG_DATA_W-1:0] sx,
                                    input logic [CFG_DATA_W-1:0] sy, output int n);
        n = frame_dim(w, LINE_WIDTH) * frame_dim(h, HEIGHT_MAX);
        program_cfg(w, h, sx, sy);
        for (int i = 0; i < n; i++) begin
            send_pixel(rand_pixel());
        end
        s_tvalid <= 1'b0;
        drain();
    endtask

    initial begin
        int                    done;
        int                    n;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting, one cell of opposite extremes.
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h7FFF);
        send_pixel(16'h8000);
        s_tvalid <= 1'b0;
        drain();

        // Largest scale on a 3x3 frame with alternating extremes in the first two rows.
        program_cfg(11'd3, 11'd3, 11'd8, 11'd8);
        send_pixel(16'h7FFF);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h8000);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h0001);
        s_tvalid <= 1'b0;
        drain();

        // Sizes and scales below the range, and a scale above it.
        program_cfg(11'd0, 11'd1, 11'd1, 11'h7FF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        s_tvalid <= 1'b0;
        drain();

        // Scale data with upper bits set, which only the low nibble decides.
        program_cfg(11'd1, 11'd0, 11'h7F9, 11'h7F3);
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
        s_tvalid <= 1'b0;
        drain();

        // Random small frames; idling shifts from the receiver to the sender, then stops.
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done < RANDOM_ITEMS / 3) begin
                snd_idle_pct = 28;
                rcv_idle_pct = 61;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                snd_idle_pct = 61;
                rcv_idle_pct = 28;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            w = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(7, 20))
                                            : CFG_DATA_W'($urandom_range(2, 6));
            if ($urandom_range(0, 19) == 0) begin
                w = CFG_DATA_W'($urandom_range(0, 1));
            end
            h = CFG_DATA_W'($urandom_range(2, 4));
            if ($urandom_range(0, 19) == 0) begin
                h = CFG_DATA_W'($urandom_range(0, 1));
            end
            run_random_frame(w, h, rand_scale(), rand_scale(), n);
            done += n;
        end

        if (mismatches == 0) begin
            $display("bilinear_upscaler: match");
        end else begin
            $display("bilinear_upscaler: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/bu_pkg.sv
design/bu_datapath.sv
design/bu_ctrl.sv
design/bilinear_upscaler.sv
sim/bilinear_upscaler_checker.sv
sim/bilinear_upscaler_tb.sv
